// File: sv/eip_pkg.sv
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
// Result word layout, status codes and protocol constants; no dependencies.
`default_nettype none

package eip_pkg;

  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [3:0]  IP_VERSION4  = 4'd4;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [5:0]  IP_HDR_MIN   = 6'd20;
  localparam logic [5:0]  TCP_HDR_MIN  = 6'd20;
  localparam logic [5:0]  UDP_HDR_LEN  = 6'd8;
  localparam logic [5:0]  ETH_TYPE_HI  = 6'd12;
  localparam logic [5:0]  ETH_TYPE_LO  = 6'd13;
  localparam logic [5:0]  HDR_END_MIN  = 6'd19;

  localparam int TDATA_W = 144;

  typedef enum logic [2:0] {
    ST_TCP_OK    = 3'd0,
    ST_UDP_OK    = 3'd1,
    ST_NOT_IPV4  = 3'd2,
    ST_BAD_IP    = 3'd3,
    ST_OTHER     = 3'd4,
    ST_BAD_L4    = 3'd5,
    ST_BAD_UDP   = 3'd6,
    ST_TRUNCATED = 3'd7
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // First member sits in the highest bits.
  typedef struct packed {
    logic        pad;
    logic [31:0] frame_crc;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [15:0] payload_len;
    logic [5:0]  l4_header_len;
    logic [7:0]  protocol;
    logic [15:0] ip_total_len;
    logic [5:0]  ip_header_len;
    logic [15:0] ether_type;
    status_t     status;
    logic [7:0]  payload_byte;
  } eip_tdata_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    eip_tdata_t data;
  } eip_res_t;

endpackage

`default_nettype wire

// File: sv/ethernet_ipv4_l4_header_parser_core.sv
// Ethernet/IPv4/TCP-UDP header parser, top level.
// Depends on eip_pkg, eip_parser and eip_obuf.
//
// Input: one frame byte per request on in_tdata, in_tlast on the last byte.
// Output: one request per L4 payload byte (out_tuser 0, byte in
// out_tdata[7:0], other bits zero) and one frame summary on the request
// that carries in_tlast (out_tuser 1): status, header fields, ports and
// the four bytes after the payload as frame_crc. Other bytes give nothing.
// Throughput: one byte per cycle while in_tready is high; the per-byte phase update is
// one level of registers behind the input handshake.
// Each result is registered in the output buffer before it shows on out_tvalid.
// A two-entry output buffer (output register plus skid) lets one result
// wait while the next byte is accepted; when both entries are full,
// in_tready drops until the receiver takes a request.
// Reset (rst_n low, synchronous): parser returns to the Ethernet header
// phase with all captured fields zero, and the output buffer empties.
// The parser also clears itself after every byte marked in_tlast.
`default_nettype none

module ethernet_ipv4_l4_header_parser_core
  import eip_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] data_byte
  input  wire logic               in_tlast,   // frame_end
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // payload_byte, status, ether_type,
                                              // ip_header_len, ip_total_len,
                                              // protocol, l4_header_len,
                                              // payload_len, src_port, dst_port,
                                              // frame_crc, one zero pad bit
  output logic                    out_tuser   // item_kind
);

  logic     step;
  eip_res_t res;

  assign step = in_tvalid && in_tready;

  eip_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .res     (res)
  );

  eip_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: sv/eip_parser.sv
// Per-byte frame parser: phase state machine, captured header fields and
// the result word for each accepted request. Depends on eip_pkg.
`default_nettype none

module eip_parser
  import eip_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output eip_res_t        res
);

  typedef enum logic [2:0] {
    PH_ETH   = 3'd0,
    PH_IP    = 3'd1,
    PH_L4    = 3'd2,
    PH_PAY   = 3'd3,
    PH_CRC   = 3'd4,
    PH_DONE  = 3'd5,
    PH_DRAIN = 3'd6
  } phase_t;

  phase_t      phase_r,    phase_nxt;
  logic [5:0]  off_r,      off_nxt;
  logic [15:0] etype_r,    etype_nxt;
  logic [5:0]  ihl_r,      ihl_nxt;
  logic [3:0]  version_r,  version_nxt;
  logic [15:0] total_r,    total_nxt;
  logic [7:0]  proto_r,    proto_nxt;
  logic [5:0]  l4hl_r,     l4hl_nxt;
  logic [7:0]  udp_hi_r,   udp_hi_nxt;
  logic [15:0] pay_left_r, pay_left_nxt;
  logic [15:0] paylen_r,   paylen_nxt;
  logic [15:0] src_r,      src_nxt;
  logic [15:0] dst_r,      dst_nxt;
  logic [31:0] crc_r,      crc_nxt;
  logic [1:0]  crc_cnt_r,  crc_cnt_nxt;
  status_t     status_r,   status_nxt;
  logic        is_pay;

  logic [15:0] ip_total;
  logic [5:0]  tcp_hl;
  logic [6:0]  hdrs;
  logic [15:0] udp_len;

  assign ip_total = {total_r[15:8], in_byte};
  assign tcp_hl   = {in_byte[7:4], 2'b00};
  assign hdrs     = {1'b0, ihl_r} + {1'b0, tcp_hl};
  assign udp_len  = {udp_hi_r, in_byte};

  always_comb begin
    phase_nxt    = phase_r;
    off_nxt      = off_r + 6'd1;
    etype_nxt    = etype_r;
    ihl_nxt      = ihl_r;
    version_nxt  = version_r;
    total_nxt    = total_r;
    proto_nxt    = proto_r;
    l4hl_nxt     = l4hl_r;
    udp_hi_nxt   = udp_hi_r;
    pay_left_nxt = pay_left_r;
    paylen_nxt   = paylen_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    crc_nxt      = crc_r;
    crc_cnt_nxt  = crc_cnt_r;
    status_nxt   = status_r;
    is_pay       = 1'b0;
    unique case (phase_r)
      PH_ETH: begin
        if (off_r == ETH_TYPE_HI) etype_nxt[15:8] = in_byte;
        if (off_r == ETH_TYPE_LO) begin
          etype_nxt[7:0] = in_byte;
          off_nxt        = '0;
          if ({etype_r[15:8], in_byte} != ETYPE_IPV4) begin
            status_nxt = ST_NOT_IPV4;
            phase_nxt  = PH_DRAIN;
          end else begin
            phase_nxt = PH_IP;
          end
        end
      end
      PH_IP: begin
        if (off_r == 6'd0) begin
          ihl_nxt     = {in_byte[3:0], 2'b00};
          version_nxt = in_byte[7:4];
        end
        if (off_r == 6'd2) total_nxt = {in_byte, 8'h00};
        if (off_r == 6'd3) begin
          total_nxt = ip_total;
          if (version_r != IP_VERSION4 || ihl_r < IP_HDR_MIN ||
              ip_total < {10'd0, ihl_r}) begin
            status_nxt = ST_BAD_IP;
            phase_nxt  = PH_DRAIN;
            off_nxt    = '0;
          end
        end
        if (off_r == 6'd9) proto_nxt = in_byte;
        if (off_r >= HDR_END_MIN && (off_r + 6'd1) == ihl_r) begin
          off_nxt = '0;
          if (proto_r == PROTO_TCP) begin
            phase_nxt = PH_L4;
          end else if (proto_r == PROTO_UDP) begin
            l4hl_nxt  = UDP_HDR_LEN;
            phase_nxt = PH_L4;
          end else begin
            status_nxt = ST_OTHER;
            phase_nxt  = PH_DRAIN;
          end
        end
      end
      PH_L4: begin
        if (off_r == 6'd0) src_nxt[15:8] = in_byte;
        if (off_r == 6'd1) src_nxt[7:0]  = in_byte;
        if (off_r == 6'd2) dst_nxt[15:8] = in_byte;
        if (off_r == 6'd3) dst_nxt[7:0]  = in_byte;
        if (proto_r == PROTO_UDP) begin
          if (off_r == 6'd4) udp_hi_nxt = in_byte;
          if (off_r == 6'd5) begin
            if (udp_len < {10'd0, UDP_HDR_LEN}) begin
              status_nxt = ST_BAD_UDP;
              phase_nxt  = PH_DRAIN;
              off_nxt    = '0;
            end else begin
              paylen_nxt = udp_len - {10'd0, UDP_HDR_LEN};
            end
          end
          if (off_r == 6'd7) begin
            pay_left_nxt = paylen_r;
            phase_nxt    = (paylen_r == 16'd0) ? PH_CRC : PH_PAY;
            off_nxt      = '0;
          end
        end else begin
          if (off_r == 6'd12) begin
            l4hl_nxt = tcp_hl;
            if (tcp_hl < TCP_HDR_MIN || total_r < {9'd0, hdrs}) begin
              status_nxt = ST_BAD_L4;
              phase_nxt  = PH_DRAIN;
              off_nxt    = '0;
            end else begin
              paylen_nxt = total_r - {9'd0, hdrs};
            end
          end
          if (off_r >= HDR_END_MIN && (off_r + 6'd1) == l4hl_r) begin
            pay_left_nxt = paylen_r;
            phase_nxt    = (paylen_r == 16'd0) ? PH_CRC : PH_PAY;
            off_nxt      = '0;
          end
        end
      end
      PH_PAY: begin
        is_pay       = 1'b1;
        pay_left_nxt = pay_left_r - 16'd1;
        off_nxt      = '0;
        if (pay_left_r == 16'd1) phase_nxt = PH_CRC;
      end
      PH_CRC: begin
        crc_nxt[{crc_cnt_r, 3'b000} +: 8] = in_byte;
        crc_cnt_nxt = crc_cnt_r + 2'd1;
        off_nxt     = '0;
        if (crc_cnt_r == 2'd3) phase_nxt = PH_DONE;
      end
      default: begin
        off_nxt = off_r;
      end
    endcase
  end

  // Form the result from the state as it stands after this byte.
  always_comb begin
    res                    = '0;
    res.data.payload_byte  = in_byte;
    if (step && in_last) begin
      res.valid              = 1'b1;
      res.kind               = KIND_SUMMARY;
      res.data.payload_byte  = 8'h00;
      if (phase_nxt == PH_DRAIN) begin
        res.data.status = status_nxt;
      end else if (phase_nxt == PH_DONE) begin
        res.data.status = (proto_nxt == PROTO_UDP) ? ST_UDP_OK : ST_TCP_OK;
      end else begin
        res.data.status = ST_TRUNCATED;
      end
      res.data.ether_type    = etype_nxt;
      res.data.ip_header_len = ihl_nxt;
      res.data.ip_total_len  = total_nxt;
      res.data.protocol      = proto_nxt;
      res.data.l4_header_len = l4hl_nxt;
      res.data.payload_len   = paylen_nxt;
      res.data.src_port      = src_nxt;
      res.data.dst_port      = dst_nxt;
      res.data.frame_crc     = crc_nxt;
    end else if (step && is_pay) begin
      res.valid = 1'b1;
      res.kind  = KIND_PAYLOAD;
    end else begin
      res.data.payload_byte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_last)) begin
      phase_r    <= PH_ETH;
      off_r      <= '0;
      etype_r    <= '0;
      ihl_r      <= '0;
      version_r  <= '0;
      total_r    <= '0;
      proto_r    <= '0;
      l4hl_r     <= '0;
      udp_hi_r   <= '0;
      pay_left_r <= '0;
      paylen_r   <= '0;
      src_r      <= '0;
      dst_r      <= '0;
      crc_r      <= '0;
      crc_cnt_r  <= '0;
      status_r   <= ST_TCP_OK;
    end else if (step) begin
      phase_r    <= phase_nxt;
      off_r      <= off_nxt;
      etype_r    <= etype_nxt;
      ihl_r      <= ihl_nxt;
      version_r  <= version_nxt;
      total_r    <= total_nxt;
      proto_r    <= proto_nxt;
      l4hl_r     <= l4hl_nxt;
      udp_hi_r   <= udp_hi_nxt;
      pay_left_r <= pay_left_nxt;
      paylen_r   <= paylen_nxt;
      src_r      <= src_nxt;
      dst_r      <= dst_nxt;
      crc_r      <= crc_nxt;
      crc_cnt_r  <= crc_cnt_nxt;
      status_r   <= status_nxt;
    end
  end

  a_pay_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> pay_left_r != 16'd0)
    else $error("payload phase with no bytes left");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_last |=> phase_r == PH_ETH && off_r == 6'd0 && crc_r == 32'd0)
    else $error("state not cleared after frame end");

  a_payload_only_in_pay: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == KIND_PAYLOAD |-> phase_r == PH_PAY && !in_last)
    else $error("payload result outside payload phase");

endmodule

`default_nettype wire

// File: sv/eip_obuf.sv
// Two-entry result buffer: output register plus skid register so the
// parser keeps taking bytes while one result waits. Depends on eip_pkg.
`default_nettype none

module eip_obuf
  import eip_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  eip_res_t                res,
  output logic                    in_ready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic                    out_tuser,
  output logic [TDATA_W-1:0]      out_tdata
);

  logic     main_valid_r;
  logic     skid_valid_r;
  eip_res_t main_r;
  eip_res_t skid_r;
  logic     pop;

  assign pop        = main_valid_r && out_tready;
  assign in_ready   = !skid_valid_r;
  assign out_tvalid = main_valid_r;
  assign out_tuser  = main_r.kind;
  assign out_tdata  = main_r.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (res.valid) begin
        main_r <= res;
      end
    end else if (res.valid) begin
      skid_r <= res;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid holds a request while output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res.valid)
    else $error("result arrived with both entries full");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r && !out_tready && res.valid |=> skid_valid_r)
    else $error("stalled result not held in skid");

endmodule

`default_nettype wire

// File: tb/eip_parse_check.sv
// Result checker for the Ethernet/IPv4/L4 header parser testbench.
// Watches both streams, tracks the frame parse per accepted byte and
// compares each result request with the oldest pending one. Needs eip_pkg.
module eip_parse_check
  import eip_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic [7:0]         in_tdata,
  input  wire logic               in_tlast,
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic [TDATA_W-1:0] out_tdata,
  input  wire logic               out_tuser,
  output int                      outstanding,
  output int                      err_count,
  output int                      payloads_seen,
  output int                      summaries_seen
);

  typedef enum logic [2:0] {
    P_ETH,
    P_IP,
    P_L4,
    P_PAY,
    P_CRC,
    P_DONE,
    P_DRAIN
  } parse_phase_t;

  typedef struct packed {
    kind_t      kind;
    eip_tdata_t data;
  } parsed_t;

  parsed_t      parsed_items[$];
  int           results_seen;

  parse_phase_t pp_phase;
  logic [15:0]  pp_off;
  logic [15:0]  pp_etype;
  logic [3:0]   pp_ver;
  logic [5:0]   pp_ihl;
  logic [15:0]  pp_total;
  logic [7:0]   pp_proto;
  logic [5:0]   pp_l4len;
  logic [15:0]  pp_udplen;
  logic [15:0]  pp_left;
  logic [15:0]  pp_paylen;
  logic [15:0]  pp_sport;
  logic [15:0]  pp_dport;
  logic [31:0]  pp_crc;
  logic [2:0]   pp_crcn;
  status_t      pp_status;

  function automatic void clear_parse();
    pp_phase  = P_ETH;
    pp_off    = '0;
    pp_etype  = '0;
    pp_ver    = '0;
    pp_ihl    = '0;
    pp_total  = '0;
    pp_proto  = '0;
    pp_l4len  = '0;
    pp_udplen = '0;
    pp_left   = '0;
    pp_paylen = '0;
    pp_sport  = '0;
    pp_dport  = '0;
    pp_crc    = '0;
    pp_crcn   = '0;
    pp_status = ST_TCP_OK;
  endfunction

  function automatic void enter(input parse_phase_t p);
    pp_phase = p;
    pp_off   = '0;
  endfunction

  function automatic void fail_frame(input status_t s);
    pp_status = s;
    enter(P_DRAIN);
  endfunction

  function automatic void start_payload();
    pp_left = pp_paylen;
    enter((pp_left == 16'd0) ? P_CRC : P_PAY);
  endfunction

  function automatic void keep_item(input parsed_t it);
    parsed_items.insert(parsed_items.size(), it);
  endfunction

  // Advance the parse by one byte; returns 1 for an L4 payload byte.
  function automatic bit parse_one(input logic [7:0] b);
    int hl;
    int hdrs;
    hl   = 0;
    hdrs = 0;
    case (pp_phase)
      P_ETH: begin
        if (pp_off == 16'(ETH_TYPE_HI)) pp_etype[15:8] = b;
        if (pp_off == 16'(ETH_TYPE_LO)) begin
          pp_etype[7:0] = b;
          if (pp_etype != ETYPE_IPV4) fail_frame(ST_NOT_IPV4);
          else enter(P_IP);
          return 1'b0;
        end
      end
      P_IP: begin
        if (pp_off == 16'd0) begin
          pp_ihl = {b[3:0], 2'b00};
          pp_ver = b[7:4];
        end
        if (pp_off == 16'd2) pp_total = {b, 8'h00};
        if (pp_off == 16'd3) begin
          pp_total[7:0] = b;
          if (pp_ver != IP_VERSION4 || pp_ihl < IP_HDR_MIN || pp_total < 16'(pp_ihl)) begin
            fail_frame(ST_BAD_IP);
            return 1'b0;
          end
        end
        if (pp_off == 16'd9) pp_proto = b;
        if (pp_off >= 16'(HDR_END_MIN) && int'(pp_off) + 1 == int'(pp_ihl)) begin
          if (pp_proto == PROTO_TCP) begin
            pp_status = ST_TCP_OK;
            enter(P_L4);
          end else if (pp_proto == PROTO_UDP) begin
            pp_status = ST_UDP_OK;
            pp_l4len  = UDP_HDR_LEN;
            enter(P_L4);
          end else begin
            fail_frame(ST_OTHER);
          end
          return 1'b0;
        end
      end
      P_L4: begin
        if (pp_off == 16'd0) pp_sport[15:8] = b;
        if (pp_off == 16'd1) pp_sport[7:0] = b;
        if (pp_off == 16'd2) pp_dport[15:8] = b;
        if (pp_off == 16'd3) pp_dport[7:0] = b;
        if (pp_proto == PROTO_UDP) begin
          if (pp_off == 16'd4) pp_udplen = {b, 8'h00};
          if (pp_off == 16'd5) begin
            pp_udplen[7:0] = b;
            if (pp_udplen < 16'(UDP_HDR_LEN)) begin
              fail_frame(ST_BAD_UDP);
              return 1'b0;
            end
            pp_paylen = pp_udplen - 16'(UDP_HDR_LEN);
          end
          if (pp_off == 16'd7) begin
            start_payload();
            return 1'b0;
          end
        end else begin
          if (pp_off == 16'd12) begin
            hl       = int'(b[7:4]) * 4;
            hdrs     = int'(pp_ihl) + hl;
            pp_l4len = hl[5:0];
            if (hl < int'(TCP_HDR_MIN) || int'(pp_total) < hdrs) begin
              fail_frame(ST_BAD_L4);
              return 1'b0;
            end
            pp_paylen = pp_total - hdrs[15:0];
          end
          if (pp_off >= 16'(HDR_END_MIN) && int'(pp_off) + 1 == int'(pp_l4len)) begin
            start_payload();
            return 1'b0;
          end
        end
      end
      P_PAY: begin
        pp_left = pp_left - 16'd1;
        if (pp_left == 16'd0) enter(P_CRC);
        return 1'b1;
      end
      P_CRC: begin
        pp_crc  = pp_crc | (32'(b) << (8 * pp_crcn[1:0]));
        pp_crcn = pp_crcn + 3'd1;
        if (pp_crcn >= 3'd4) enter(P_DONE);
        return 1'b0;
      end
      default: return 1'b0;
    endcase
    pp_off = pp_off + 16'd1;
    return 1'b0;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    parsed_t item;
    bit      is_pay;
    is_pay = parse_one(b);
    item   = '0;
    if (!last) begin
      if (is_pay) begin
        item.kind              = KIND_PAYLOAD;
        item.data.payload_byte = b;
        keep_item(item);
      end
    end else begin
      item.kind = KIND_SUMMARY;
      if (pp_phase == P_DRAIN) item.data.status = pp_status;
      else if (pp_phase == P_DONE)
        item.data.status = (pp_proto == PROTO_UDP) ? ST_UDP_OK : ST_TCP_OK;
      else item.data.status = ST_TRUNCATED;
      item.data.ether_type    = pp_etype;
      item.data.ip_header_len = pp_ihl;
      item.data.ip_total_len  = pp_total;
      item.data.protocol      = pp_proto;
      item.data.l4_header_len = pp_l4len;
      item.data.payload_len   = pp_paylen;
      item.data.src_port      = pp_sport;
      item.data.dst_port      = pp_dport;
      item.data.frame_crc     = pp_crc;
      keep_item(item);
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("check: result %0d: %s", results_seen, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got_v,
                               input logic [63:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got_v, want_v));
  endtask

  always @(posedge clk) begin : watch
    parsed_t want;
    parsed_t got;
    if (!rst_n) begin
      clear_parse();
      parsed_items.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind = kind_t'(out_tuser);
        got.data = out_tdata;
        if (parsed_items.size() == 0) begin
          report_mismatch($sformatf("request with nothing pending, tuser %0b", out_tuser));
        end else begin
          want = parsed_items.pop_front();
          compare_field("item_kind", got.kind, want.kind);
          compare_field("payload_byte", got.data.payload_byte, want.data.payload_byte);
          compare_field("status", got.data.status, want.data.status);
          compare_field("ether_type", got.data.ether_type, want.data.ether_type);
          compare_field("ip_header_len", got.data.ip_header_len, want.data.ip_header_len);
          compare_field("ip_total_len", got.data.ip_total_len, want.data.ip_total_len);
          compare_field("protocol", got.data.protocol, want.data.protocol);
          compare_field("l4_header_len", got.data.l4_header_len, want.data.l4_header_len);
          compare_field("payload_len", got.data.payload_len, want.data.payload_len);
          compare_field("src_port", got.data.src_port, want.data.src_port);
          compare_field("dst_port", got.data.dst_port, want.data.dst_port);
          compare_field("frame_crc", got.data.frame_crc, want.data.frame_crc);
          compare_field("pad", got.data.pad, want.data.pad);
          if (want.kind == KIND_SUMMARY) summaries_seen++;
          else payloads_seen++;
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
      outstanding <= parsed_items.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the header parser testbench: clock, reset, frame stimulus and verdict.
// Drives ethernet_ipv4_l4_header_parser_core and hands checking to
// eip_parse_check; needs eip_pkg.
module testbench
  import eip_pkg::*;
();

  localparam int          CYCLE_LIMIT = 500000;
  localparam int          PHASE_BYTES = 80;
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [3:0]  IP_VERSION6 = 4'd6;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = 8'h00;
  logic               in_tlast   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  int tx_idle_pct = 6;
  int rx_idle_pct = 78;
  int outstanding;
  int err_count;
  int payloads_seen;
  int summaries_seen;
  int bytes_sent  = 0;
  int frames_sent = 0;
  int cycles      = 0;

  logic [7:0] frame_bytes[$];

  ethernet_ipv4_l4_header_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  eip_parse_check checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .outstanding    (outstanding),
    .err_count      (err_count),
    .payloads_seen  (payloads_seen),
    .summaries_seen (summaries_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("testbench: timeout after %0d cycles, %0d results pending", cycles, outstanding);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [15:0] clamp16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  // len_adj shifts the length field: IP total for TCP and other protocols,
  // UDP length for UDP. cut < 0 picks a random cut point, cut 0 keeps all.
  task automatic build_frame(input logic [15:0] etype, input logic [3:0] ver,
                             input logic [3:0] ihl, input logic [7:0] proto,
                             input logic [3:0] doff, input int pay_n, input int len_adj,
                             input int crc_n, input int extra_n, input int cut);
    int          ip_n;
    int          l4_n;
    int          i;
    int          keep;
    logic [15:0] tot;
    logic [15:0] ulen;
    logic [15:0] sp;
    logic [15:0] dp;
    frame_bytes.delete();
    sp   = pick16();
    dp   = pick16();
    ip_n = (int'(ihl) < 5) ? 20 : int'(ihl) * 4;
    if (proto == PROTO_TCP) begin
      l4_n = (int'(doff) < 5) ? 20 : int'(doff) * 4;
      tot  = clamp16(int'(ihl) * 4 + int'(doff) * 4 + pay_n + len_adj);
    end else if (proto == PROTO_UDP) begin
      l4_n = 8;
      tot  = clamp16(int'(ihl) * 4 + 8 + pay_n);
    end else begin
      l4_n = 0;
      tot  = clamp16(int'(ihl) * 4 + pay_n + len_adj);
    end
    ulen = clamp16(8 + pay_n + len_adj);
    repeat (12) add_byte(8'($urandom));
    add_byte(etype[15:8]);
    add_byte(etype[7:0]);
    for (i = 0; i < ip_n; i++) begin
      case (i)
        0: add_byte({ver, ihl});
        2: add_byte(tot[15:8]);
        3: add_byte(tot[7:0]);
        9: add_byte(proto);
        default: add_byte(8'($urandom));
      endcase
    end
    for (i = 0; i < l4_n; i++) begin
      if (i == 0) add_byte(sp[15:8]);
      else if (i == 1) add_byte(sp[7:0]);
      else if (i == 2) add_byte(dp[15:8]);
      else if (i == 3) add_byte(dp[7:0]);
      else if (proto == PROTO_UDP && i == 4) add_byte(ulen[15:8]);
      else if (proto == PROTO_UDP && i == 5) add_byte(ulen[7:0]);
      else if (proto == PROTO_TCP && i == 12) add_byte({doff, 4'($urandom)});
      else add_byte(8'($urandom));
    end
    repeat (pay_n + crc_n + extra_n) add_byte(8'($urandom));
    keep = (cut < 0) ? $urandom_range(1, frame_bytes.size()) : cut;
    if (keep > 0 && keep < frame_bytes.size()) frame_bytes = frame_bytes[0:keep-1];
  endtask

  task automatic build_noise(input int n, input int fill);
    frame_bytes.delete();
    repeat (n) add_byte((fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= frame_bytes[i];
      in_tlast  <= (i == frame_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bytes_sent++;
    end
    frames_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_random(input int budget);
    int          start;
    int          r;
    int          pay_n;
    int          adj;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    logic [15:0] etype;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r     = $urandom_range(99);
      pay_n = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      ihl   = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
      doff  = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
      proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
      adj   = ($urandom_range(4) == 0) ? 70000 : int'($urandom_range(0, 60)) - 30;
      case ($urandom_range(2))
        0: etype = ETYPE_ARP;
        1: etype = ETYPE_IPV6;
        default: etype = pick16();
      endcase
      if (r < 65)
        build_frame(ETYPE_IPV4, IP_VERSION4, ihl, proto, doff, pay_n, 0, 4,
                    ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, 0);
      else if (r < 75)
        build_frame(ETYPE_IPV4, IP_VERSION4, ihl, proto, doff, pay_n, adj, 4, 0,
                    $urandom_range(1) ? -1 : 0);
      else if (r < 82)
        build_frame(ETYPE_IPV4, 4'($urandom), 4'($urandom), 8'($urandom), 4'($urandom),
                    pay_n, 0, 4, 0, 0);
      else if (r < 88)
        build_frame(etype, IP_VERSION4, ihl, proto, doff, pay_n, 0, 4, 0, -1);
      else if (r < 94)
        build_frame(ETYPE_IPV4, IP_VERSION4, ihl, proto, doff, pay_n, 0, 4, 0, -1);
      else
        build_noise($urandom_range(1, 40), -1);
      send_frame();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 0, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd15, PROTO_TCP, 4'd15, 3, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_UDP, 4'd0, 0, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd6, PROTO_UDP, 4'd0, 5, 0, 4, 3, 0);
    send_frame();
    build_frame(ETYPE_ARP, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 0, 0, 4, 0, 14);
    send_frame();
    build_frame(ETYPE_IPV6, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 2, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION6, 4'd5, PROTO_TCP, 4'd5, 2, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd4, PROTO_TCP, 4'd5, 2, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 0, -200, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_ICMP, 4'd0, 4, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_TCP, 4'd4, 2, 0, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 0, -1, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_UDP, 4'd0, 0, -1, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 6, 0, 4, 0, 57);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 2, 0, 4, 0, 58);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_TCP, 4'd5, 2, 70000, 4, 0, 0);
    send_frame();
    build_frame(ETYPE_IPV4, IP_VERSION4, 4'd5, PROTO_UDP, 4'd0, 3, 70000, 4, 0, 0);
    send_frame();
    build_noise(1, -1);
    send_frame();
    build_noise(20, 8'hFF);
    send_frame();
    build_noise(20, 8'h00);
    send_frame();

    // hold the sender until every pending result has drained, then vary pacing
    drain_results();
    run_random(PHASE_BYTES);
    drain_results();
    tx_idle_pct <= 78;
    rx_idle_pct <= 6;
    run_random(PHASE_BYTES);
    drain_results();
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    run_random(PHASE_BYTES);
    drain_results();
    repeat (8) @(posedge clk);

    $display("testbench: %0d frames, %0d bytes over three pacing phases", frames_sent,
             bytes_sent);
    $display("testbench: %0d payload bytes and %0d frame summaries compared", payloads_seen,
             summaries_seen);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
